/* hdl/acl_pkg.sv */
// Shared types and constants of the access code lockout session gate
package acl_pkg;

    typedef enum logic [1:0] {
        MODE_LOGIN = 2'd0,
        MODE_AUTH  = 2'd1,
        MODE_TOUCH = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNAUTH  = 3'd1,
        ST_LOCKED  = 3'd2,
        ST_BADCODE = 3'd3,
        ST_BUSY    = 3'd4,
        ST_EXPIRED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_PIN_CODE     = 2'd0,
        REG_MAX_FAILURES = 2'd1,
        REG_LOCKOUT_US   = 2'd2,
        REG_IDLE_TIMEOUT = 2'd3
    } reg_index_t;

    localparam int CFG_DATA_W = 63;

    localparam logic [47:0] PIN_CODE_RST     = 48'd0;
    localparam logic [3:0]  MAX_FAILURES_RST = 4'd5;
    localparam logic [62:0] LOCKOUT_US_RST   = 63'd60000000;
    localparam logic [62:0] IDLE_TIMEOUT_RST = 63'd600000000;

    localparam logic [7:0]  CHAR_ZERO = 8'h30;
    localparam logic [7:0]  CHAR_NINE = 8'h39;
    localparam logic [63:0] MAX_S64   = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [47:0] pin_code;
        logic [3:0]  max_failures;
        logic [62:0] lockout_us;
        logic [62:0] idle_timeout_us;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] now_us;
        logic [47:0] code_chars;
        logic [2:0]  code_length;
        logic [63:0] token_hi;
        logic [63:0] token_lo;
        logic        token_format_ok;
        logic        xfer_busy;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] issued_token_hi;
        logic [63:0] issued_token_lo;
        logic        session_open;
        logic [3:0]  failure_count;
    } rsp_t;

endpackage

/* hdl/acl_cfg.sv */
// Configuration register file of the access code lockout session gate
module acl_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_index,
    input  logic [acl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output acl_pkg::cfg_t                   cfg
);

    acl_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pin_code        <= acl_pkg::PIN_CODE_RST;
            cfg_reg.max_failures    <= acl_pkg::MAX_FAILURES_RST;
            cfg_reg.lockout_us      <= acl_pkg::LOCKOUT_US_RST;
            cfg_reg.idle_timeout_us <= acl_pkg::IDLE_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                acl_pkg::REG_PIN_CODE:     cfg_reg.pin_code        <= cfg_wdata[47:0];
                acl_pkg::REG_MAX_FAILURES: cfg_reg.max_failures    <= cfg_wdata[3:0];
                acl_pkg::REG_LOCKOUT_US:   cfg_reg.lockout_us      <= cfg_wdata;
                acl_pkg::REG_IDLE_TIMEOUT: cfg_reg.idle_timeout_us <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/acl_eval.sv */
// Session state and per-request decision logic of the access code gate
module acl_eval #(
    parameter int CODE_DIGITS = 6,
    parameter int TOKEN_BYTES = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          advance,
    input  acl_pkg::req_t req,
    input  acl_pkg::cfg_t cfg,
    output acl_pkg::rsp_t rsp
);

    localparam logic [47:0] CodeMask = (CODE_DIGITS >= 6) ? {48{1'b1}} :
        48'((64'd1 << (8 * CODE_DIGITS)) - 64'd1);
    localparam logic [63:0] LoMask = (TOKEN_BYTES >= 16) ? {64{1'b1}} :
        (TOKEN_BYTES <= 8) ? 64'd0 : ({64{1'b1}} << (64 - 8 * (TOKEN_BYTES - 8)));

    logic [63:0] tok_hi_reg, tok_hi_next;
    logic [63:0] tok_lo_reg, tok_lo_next;
    logic        active_reg, active_next;
    logic [63:0] last_reg, last_next;
    logic [3:0]  fails_reg, fails_next;
    logic [63:0] lock_reg, lock_next;

    logic [63:0] hi_in, lo_in, diff, sum, lock_sat, chars64;
    logic        neg, expired, fmt, match, tok_match, newer;
    logic [3:0]  fails1, fails_inc;
    logic [7:0]  ch;
    logic [2:0]  status;
    logic [63:0] out_hi, out_lo;

    always_comb begin
        hi_in     = req.token_hi;
        lo_in     = req.token_lo & LoMask;
        neg       = req.now_us[63];
        diff      = req.now_us - last_reg;
        expired   = active_reg && (($signed(req.now_us) < $signed(last_reg)) ||
                    (diff >= {1'b0, cfg.idle_timeout_us}));
        chars64   = {16'd0, req.code_chars};
        fmt       = (int'(req.code_length) == CODE_DIGITS);
        ch        = '0;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            ch  = chars64[8*i +: 8];
            fmt = fmt && (ch >= acl_pkg::CHAR_ZERO) && (ch <= acl_pkg::CHAR_NINE);
        end
        match     = ((req.code_chars ^ cfg.pin_code) & CodeMask) == 48'd0;
        fails1    = (lock_reg != 64'd0) ? 4'd0 : fails_reg;
        fails_inc = (fails1 < cfg.max_failures) ? fails1 + 4'd1 : fails1;
        sum       = req.now_us + {1'b0, cfg.lockout_us};
        lock_sat  = sum[63] ? acl_pkg::MAX_S64 : sum;
        tok_match = (hi_in == tok_hi_reg) && (lo_in == tok_lo_reg);
        newer     = $signed(last_reg) < $signed(req.now_us);

        tok_hi_next = tok_hi_reg;
        tok_lo_next = tok_lo_reg;
        active_next = active_reg;
        last_next   = last_reg;
        fails_next  = fails_reg;
        lock_next   = lock_reg;
        status      = acl_pkg::ST_UNAUTH;
        out_hi      = '0;
        out_lo      = '0;

        case (req.mode)
            acl_pkg::MODE_LOGIN: begin
                if (neg) begin
                    status = acl_pkg::ST_UNAUTH;
                end else if ($signed(req.now_us) < $signed(lock_reg)) begin
                    status = acl_pkg::ST_LOCKED;
                end else if (active_reg && !expired) begin
                    lock_next  = '0;
                    fails_next = fails1;
                    status     = acl_pkg::ST_BUSY;
                end else begin
                    tok_hi_next = '0;
                    tok_lo_next = '0;
                    active_next = 1'b0;
                    last_next   = '0;
                    lock_next   = '0;
                    fails_next  = fails1;
                    if (!fmt || !match) begin
                        fails_next = fails_inc;
                        if (fails_inc >= cfg.max_failures) begin
                            lock_next = lock_sat;
                            status    = acl_pkg::ST_LOCKED;
                        end else begin
                            status    = acl_pkg::ST_BADCODE;
                        end
                    end else begin
                        tok_hi_next = hi_in;
                        tok_lo_next = lo_in;
                        active_next = 1'b1;
                        last_next   = req.now_us;
                        fails_next  = '0;
                        out_hi      = hi_in;
                        out_lo      = lo_in;
                        status      = acl_pkg::ST_OK;
                    end
                end
            end
            acl_pkg::MODE_AUTH: begin
                if (neg || !active_reg) begin
                    status = acl_pkg::ST_UNAUTH;
                end else if (!req.xfer_busy && expired) begin
                    tok_hi_next = '0;
                    tok_lo_next = '0;
                    active_next = 1'b0;
                    last_next   = '0;
                    status      = acl_pkg::ST_EXPIRED;
                end else if (!req.token_format_ok || !tok_match) begin
                    status = acl_pkg::ST_UNAUTH;
                end else begin
                    if (newer) begin
                        last_next = req.now_us;
                    end
                    status = acl_pkg::ST_OK;
                end
            end
            acl_pkg::MODE_TOUCH: begin
                if (active_reg && !neg && newer) begin
                    last_next = req.now_us;
                end
                status = acl_pkg::ST_OK;
            end
            default: status = acl_pkg::ST_UNAUTH;
        endcase

        rsp.status          = status;
        rsp.issued_token_hi = out_hi;
        rsp.issued_token_lo = out_lo;
        rsp.session_open    = active_next;
        rsp.failure_count   = fails_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_hi_reg <= '0;
            tok_lo_reg <= '0;
            active_reg <= 1'b0;
            last_reg   <= '0;
            fails_reg  <= '0;
            lock_reg   <= '0;
        end else if (advance) begin
            tok_hi_reg <= tok_hi_next;
            tok_lo_reg <= tok_lo_next;
            active_reg <= active_next;
            last_reg   <= last_next;
            fails_reg  <= fails_next;
            lock_reg   <= lock_next;
        end
    end

endmodule

/* hdl/access_code_lockout_session_gate_top.sv */
// Top level of the access code lockout session gate
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    mode, time, code, token, flags
//   m_        out        m_valid/m_ready    status, issued token, session, failures
//   cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// One request per cycle sustained while m_ready is high.
// The request register feeds the decision logic, which updates session state
// and loads the result register in the same cycle.
// A stalled result holds the pipe; the request register still takes one request.
// aresetn is synchronous: it clears session state, counters and configuration.
module access_code_lockout_session_gate_top #(
    parameter int CODE_DIGITS = 6,
    parameter int TOKEN_BYTES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_mode,
    input  logic signed [63:0]              s_now_us,
    input  logic [47:0]                     s_code_chars,
    input  logic [2:0]                      s_code_length,
    input  logic [63:0]                     s_token_hi,
    input  logic [63:0]                     s_token_lo,
    input  logic                            s_token_format_ok,
    input  logic                            s_xfer_busy,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_status,
    output logic [63:0]                     m_issued_token_hi,
    output logic [63:0]                     m_issued_token_lo,
    output logic                            m_session_open,
    output logic [3:0]                      m_failure_count,
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_index,
    input  logic [acl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    acl_pkg::cfg_t cfg;
    acl_pkg::req_t req_reg;
    acl_pkg::rsp_t rsp, rsp_reg;
    logic          in_valid_reg, in_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic          advance, take;

    acl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    acl_eval #(
        .CODE_DIGITS (CODE_DIGITS),
        .TOKEN_BYTES (TOKEN_BYTES)
    ) u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .req     (req_reg),
        .cfg     (cfg),
        .rsp     (rsp)
    );

    always_comb begin
        advance        = in_valid_reg && (!out_valid_reg || m_ready);
        s_ready        = !in_valid_reg || advance;
        take           = s_valid && s_ready;
        in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            req_reg.mode            <= s_mode;
            req_reg.now_us          <= s_now_us;
            req_reg.code_chars      <= s_code_chars;
            req_reg.code_length     <= s_code_length;
            req_reg.token_hi        <= s_token_hi;
            req_reg.token_lo        <= s_token_lo;
            req_reg.token_format_ok <= s_token_format_ok;
            req_reg.xfer_busy       <= s_xfer_busy;
        end
        if (advance) begin
            rsp_reg <= rsp;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = rsp_reg.status;
    assign m_issued_token_hi = rsp_reg.issued_token_hi;
    assign m_issued_token_lo = rsp_reg.issued_token_lo;
    assign m_session_open    = rsp_reg.session_open;
    assign m_failure_count   = rsp_reg.failure_count;

endmodule

/* hdl/acl_checker.sv */
// Port-level checks of the access code lockout session gate and their binding
module acl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [63:0] m_issued_token_hi,
    input logic [63:0] m_issued_token_lo,
    input logic        m_session_open
);

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_issued_token_hi) && $stable(m_issued_token_lo))
        else $error("stalled result changed");

    a_token_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != acl_pkg::ST_OK)
            |-> (m_issued_token_hi == 64'd0) && (m_issued_token_lo == 64'd0))
        else $error("token issued without successful login");

    a_busy_keeps_session: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == acl_pkg::ST_BUSY) |-> m_session_open)
        else $error("busy reported without open session");

    a_expired_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == acl_pkg::ST_EXPIRED) |-> !m_session_open)
        else $error("expired session still open");

endmodule

bind access_code_lockout_session_gate_top acl_checker u_acl_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_issued_token_hi (m_issued_token_hi),
    .m_issued_token_lo (m_issued_token_lo),
    .m_session_open    (m_session_open)
);
